### rtl/rsnh_pkg.sv
// Shared types and constants for the ray/sphere nearest-hit unit.
package rsnh_pkg;

  // Ray word: origin in signed Q11.4, direction in signed Q1.14.
  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } ray_t;

  // Result word: distance in unsigned Q14.4.
  typedef struct packed {
    logic        hit;
    logic [1:0]  hit_index;
    logic [17:0] hit_distance;
  } result_t;

  localparam int DistW     = 22;
  localparam int SqrtW     = 42;
  localparam int SqrtSteps = 21;

  // Per-sphere outcome leaving one lane.
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [DistW-1:0] hit_dist;
  } lane_out_t;

  localparam logic [2:0]  RegCount    = 3'd0;
  localparam logic [2:0]  RegSlotBase = 3'd1;
  localparam logic [17:0] DistMax     = 18'h3FFFF;

endpackage

### rtl/rsnh_lane.sv
// One sphere lane: pipelined geometric intersection with a staged square root.
module rsnh_lane import rsnh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        en,
  input  ray_t        ray,
  input  logic [63:0] slot,
  output lane_out_t   lane_out
);

  // Stage 1: L = center - origin
  logic               vld1, ok1;
  logic signed [16:0] l1 [3];
  logic signed [15:0] d1 [3];
  logic        [15:0] r1;

  // Stage 2: products
  logic               vld2, ok2;
  logic signed [32:0] pld2 [3];
  logic signed [33:0] pll2 [3];
  logic        [31:0] r2_2;

  // Stage 3: sums, tca
  logic               vld3, ok3;
  logic signed [20:0] tca3;
  logic signed [34:0] ll3;
  logic        [31:0] r2_3;
  logic signed [34:0] ld_sum, ll_sum;

  // Stage 4: tca squared
  logic               vld4, ok4;
  logic signed [20:0] tca4;
  logic signed [34:0] ll4;
  logic signed [41:0] tsq4;
  logic        [31:0] r2_4;

  // Stage 5: d2 check
  logic signed [42:0] d2, r2s, rem;

  // Square root chain
  logic             sq_vld [SqrtSteps+1];
  logic             sq_ok  [SqrtSteps+1];
  logic signed [20:0] sq_tca [SqrtSteps+1];
  logic [SqrtW-1:0] sq_n   [SqrtSteps+1];
  logic [SqrtW-1:0] sq_res [SqrtSteps+1];

  logic signed [22:0] t0, t1;
  logic [20:0]        thc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else begin
      vld1 <= start;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    ok1   <= en;
    l1[0] <= {slot[15], slot[15:0]}  - {ray.origin_x[15], ray.origin_x};
    l1[1] <= {slot[31], slot[31:16]} - {ray.origin_y[15], ray.origin_y};
    l1[2] <= {slot[47], slot[47:32]} - {ray.origin_z[15], ray.origin_z};
    d1[0] <= ray.dir_x;
    d1[1] <= ray.dir_y;
    d1[2] <= ray.dir_z;
    r1    <= slot[63:48];

    ok2  <= ok1;
    r2_2 <= r1 * r1;
    for (int k = 0; k < 3; k++) begin
      pld2[k] <= l1[k] * d1[k];
      pll2[k] <= l1[k] * l1[k];
    end

    ok3  <= ok2;
    tca3 <= ld_sum[34:14];
    ll3  <= ll_sum;
    r2_3 <= r2_2;

    ok4  <= ok3;
    tca4 <= tca3;
    ll4  <= ll3;
    tsq4 <= tca3 * tca3;
    r2_4 <= r2_3;
  end

  always_comb begin
    ld_sum = 35'(pld2[0]) + 35'(pld2[1]) + 35'(pld2[2]);
    ll_sum = 35'(pll2[0]) + 35'(pll2[1]) + 35'(pll2[2]);
    d2     = 43'(ll4) - 43'(tsq4);
    r2s    = $signed({11'b0, r2_4});
    rem    = r2s - d2;
  end

  // Enter the square root chain
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else begin
      sq_vld[0] <= vld4;
    end
    sq_ok[0]  <= ok4 && !(d2 > r2s);
    sq_tca[0] <= tca4;
    sq_n[0]   <= rem[SqrtW-1:0];
    sq_res[0] <= '0;
  end

  // One root bit per stage
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [SqrtW-1:0] Bit = SqrtW'(1) << (2 * (SqrtSteps - 1 - k));
    logic [SqrtW-1:0] trial;
    logic             take;

    always_comb begin
      trial = sq_res[k] + Bit;
      take  = sq_n[k] >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else begin
        sq_vld[k+1] <= sq_vld[k];
      end
      sq_ok[k+1]  <= sq_ok[k];
      sq_tca[k+1] <= sq_tca[k];
      if (take) begin
        sq_n[k+1]   <= sq_n[k] - trial;
        sq_res[k+1] <= (sq_res[k] >> 1) + Bit;
      end else begin
        sq_n[k+1]   <= sq_n[k];
        sq_res[k+1] <= sq_res[k] >> 1;
      end
    end
  end

  always_comb begin
    thc = sq_res[SqrtSteps][20:0];
    t0  = 23'(sq_tca[SqrtSteps]) - $signed({2'b0, thc});
    t1  = 23'(sq_tca[SqrtSteps]) + $signed({2'b0, thc});
  end

  // Pick near or far crossing
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.vld <= 1'b0;
    end else begin
      lane_out.vld <= sq_vld[SqrtSteps];
    end
    lane_out.hit      <= sq_ok[SqrtSteps] && (!t0[22] || !t1[22]);
    lane_out.hit_dist <= !t0[22] ? t0[DistW-1:0] : t1[DistW-1:0];
  end

endmodule

### rtl/ray_sphere_nearest_hit_unit.sv
// Top level of the ray/sphere nearest-hit unit.
//
// Takes one ray word per clock whenever start is high (busy is always low)
// and returns exactly one result word, marked by done for one cycle; the
// receiver cannot stall, so the pipeline simply advances every cycle. The
// depth is set by the square root of r^2 - d2, which resolves one root bit
// per stage over 21 stages; the rest is 5 stages of difference, products,
// sums, tca^2 and the miss test, one stage choosing t0 or t1, and a
// two-level registered minimum tree over the sphere lanes. Each sphere slot
// has its own lane, all working in parallel. Write the configuration
// registers only while no ray is in flight: sphere_count at index 0, slots
// 0..3 at indexes 1..4. A count above MAX_SPHERES acts as MAX_SPHERES; on
// equal distances the lower slot wins; the reported distance saturates at
// the largest Q14.4 value.
module ray_sphere_nearest_hit_unit import rsnh_pkg::*; #(
  parameter int MAX_SPHERES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  ray_t        ray,
  output logic        done,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef struct packed {
    logic             hit;
    logic [1:0]       idx;
    logic [DistW-1:0] hit_dist;
  } cand_t;

  logic [2:0]  sphere_count;
  logic [63:0] slot [MAX_SPHERES];

  lane_out_t lane_out [4];
  cand_t     cand [4];
  cand_t     pair_a, pair_b, pair_a_next, pair_b_next, best;
  logic      vld_t1;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_count <= '0;
      for (int i = 0; i < MAX_SPHERES; i++) begin
        slot[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == RegCount) begin
        sphere_count <= cfg_data[2:0];
      end
      for (int i = 0; i < MAX_SPHERES; i++) begin
        if (cfg_index == RegSlotBase + 3'(i)) begin
          slot[i] <= cfg_data;
        end
      end
    end
  end

  // Sphere lanes; missing lanes never hit
  for (genvar i = 0; i < 4; i++) begin : g_lane
    if (i < MAX_SPHERES) begin : g_on
      rsnh_lane u_lane (
        .clk      (clk),
        .rst      (rst),
        .start    (start),
        .en       (sphere_count > 3'(i)),
        .ray      (ray),
        .slot     (slot[i]),
        .lane_out (lane_out[i])
      );
    end else begin : g_off
      assign lane_out[i] = '0;
    end
    assign cand[i] = '{hit: lane_out[i].hit, idx: 2'(i), hit_dist: lane_out[i].hit_dist};
  end

  // Take b only on a strictly nearer hit, so the lower slot wins ties
  function automatic cand_t pick(cand_t a, cand_t b);
    if (b.hit && (!a.hit || b.hit_dist < a.hit_dist)) begin
      return b;
    end
    return a;
  endfunction

  always_comb begin
    pair_a_next = pick(cand[0], cand[1]);
    pair_b_next = pick(cand[2], cand[3]);
    best        = pick(pair_a, pair_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_t1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      vld_t1 <= lane_out[0].vld;
      done   <= vld_t1;
    end
    pair_a <= pair_a_next;
    pair_b <= pair_b_next;
    // Clamp distance, zero the fields on a miss
    result.hit <= best.hit;
    result.hit_index <= best.hit ? best.idx : 2'd0;
    if (!best.hit) begin
      result.hit_distance <= '0;
    end else if (best.hit_dist > DistW'(DistMax)) begin
      result.hit_distance <= DistMax;
    end else begin
      result.hit_distance <= best.hit_dist[17:0];
    end
  end

endmodule
